// ===== hdl/pm4_csp_pkg.sv =====
// Package for the PM4 command stream parser: constants, opcodes and the result record type.
`default_nettype none
package pm4_csp_pkg;

	localparam int OFFSET_BITS        = 24;
	localparam int KEPT_PAYLOAD_WORDS = 5;
	localparam int KEPT_IDX_W         = $clog2(KEPT_PAYLOAD_WORDS);
	localparam int COUNT_W            = 14;
	localparam int PARSED_W           = 24;
	localparam int FIFO_DEPTH         = 4;
	localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W         = FIFO_PTR_W + 1;

	localparam logic [1:0] HDR_TYPE3 = 2'h3;

	localparam logic [7:0] OP_DRAW_INDEX_2    = 8'h27;
	localparam logic [7:0] OP_INDEX_TYPE      = 8'h2A;
	localparam logic [7:0] OP_DRAW_INDEX_AUTO = 8'h2D;
	localparam logic [7:0] OP_SET_CONTEXT_REG = 8'h69;

	localparam logic [15:0] REG_RT_FORMAT = 16'h0001;
	localparam logic [15:0] REG_DS_FORMAT = 16'h0002;
	localparam logic [15:0] REG_BLEND     = 16'h0010;
	localparam logic [15:0] REG_DEPTH     = 16'h0020;
	localparam logic [15:0] REG_VIEWPORT  = 16'h0030;

	localparam logic KIND_DRAW    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [31:0]         draw_indices;
		logic [63:0]         index_base_address;
		logic [5:0]          topology;
		logic [PARSED_W-1:0] parsed_len;
		logic [3:0]          state_flags;
		logic [31:0]         color_format;
		logic [31:0]         depth_surface_format;
		logic [15:0]         vp_width;
		logic [15:0]         vp_height;
		logic [31:0]         packets_total;
		logic                last;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/pm4_command_stream_parser.sv =====
// Top level of the PM4 command stream parser: word decode, context state and result queue.
//
//  channel | direction | handshake              | payload
//  cmd     | in        | cmd_valid / cmd_stall  | word, last_word
//  rec     | out       | rec_valid / rec_stall  | kind .. last (one result per transaction)
//
//  One command word per cycle while cmd_stall is low. A word is registered,
//  decoded against the packet state, and its zero, one or two results go into a
//  four-entry result queue and are presented behind any results queued before them.
//  A word that ends a draw packet on the buffer's last word yields two results.
//  cmd_stall rises while a word is held and the queue has fewer than two free entries.
//  Reset clears packet tracking, context state, counters and the queue.
`default_nettype none
module pm4_command_stream_parser (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire logic [31:0]                       word,
	input  wire logic                              last_word,
	output logic                                   rec_valid,
	input  wire logic                              rec_stall,
	output logic                                   kind,
	output logic [31:0]                            draw_indices,
	output logic [63:0]                            index_base_address,
	output logic [5:0]                             topology,
	output logic [pm4_csp_pkg::PARSED_W-1:0]       parsed_len,
	output logic [3:0]                             state_flags,
	output logic [31:0]                            color_format,
	output logic [31:0]                            depth_surface_format,
	output logic [15:0]                            vp_width,
	output logic [15:0]                            vp_height,
	output logic [31:0]                            packets_total,
	output logic                                   last
);
	import pm4_csp_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;

	logic                   in_packet_q;
	logic [7:0]             opcode_q;
	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     ppos_q;
	logic [31:0]            payload_q [KEPT_PAYLOAD_WORDS];
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [3:0]             ctx_q;
	logic [31:0]            rt_q;
	logic [31:0]            ds_q;
	logic [31:0]            vp_q;
	logic [31:0]            tally_q;

	logic                   in_packet_n;
	logic [7:0]             opcode_n;
	logic [COUNT_W-1:0]     count_n;
	logic [COUNT_W-1:0]     ppos_n;
	logic [OFFSET_BITS-1:0] offset_n;
	logic [OFFSET_BITS-1:0] start_n;
	logic [3:0]             ctx_n;
	logic [31:0]            rt_n;
	logic [31:0]            ds_n;
	logic [31:0]            vp_n;
	logic [31:0]            tally_n;
	logic                   pl_write;

	result_t fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	result_t r0;
	result_t r1;
	logic [1:0] nres;
	logic room;
	logic adv;
	logic pop;

	function automatic logic [31:0] pl_at(input logic [COUNT_W-1:0] i,
			input logic [COUNT_W-1:0] cnt, input logic [COUNT_W-1:0] p,
			input logic [31:0] cur, input logic [31:0] stored);
		logic [31:0] v;
		if (i > cnt) begin
			v = '0;
		end else if (i == p) begin
			v = cur;
		end else begin
			v = stored;
		end
		return v;
	endfunction

	assign room      = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign adv       = valid_s1 && room;
	assign cmd_stall = valid_s1 && !room;
	assign rec_valid = cnt_q != '0;
	assign pop       = rec_valid && !rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			word_s1 <= word;
			last_s1 <= last_word;
		end
	end

	always_comb begin
		logic [31:0] p0;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic        draw;
		logic [OFFSET_BITS-1:0] parsed;
		logic [PARSED_W-1:0]    parsed_sat;
		result_t d;
		result_t s;

		in_packet_n = in_packet_q;
		opcode_n    = opcode_q;
		count_n     = count_q;
		ppos_n      = ppos_q;
		start_n     = start_q;
		ctx_n       = ctx_q;
		rt_n        = rt_q;
		ds_n        = ds_q;
		vp_n        = vp_q;
		tally_n     = tally_q;
		pl_write    = 1'b0;
		draw        = 1'b0;
		d           = '0;
		d.kind      = KIND_DRAW;

		p0 = pl_at(COUNT_W'(0), count_q, ppos_q, word_s1, payload_q[0]);
		p1 = pl_at(COUNT_W'(1), count_q, ppos_q, word_s1, payload_q[1]);
		p2 = pl_at(COUNT_W'(2), count_q, ppos_q, word_s1, payload_q[2]);
		p3 = pl_at(COUNT_W'(3), count_q, ppos_q, word_s1, payload_q[3]);

		if (!in_packet_q) begin
			if (word_s1[31:30] == HDR_TYPE3) begin
				tally_n     = tally_q + 32'd1;
				in_packet_n = 1'b1;
				opcode_n    = word_s1[15:8];
				count_n     = word_s1[29:16];
				ppos_n      = '0;
				start_n     = offset_q;
			end
		end else begin
			pl_write = ppos_q < COUNT_W'(KEPT_PAYLOAD_WORDS);
			if (ppos_q >= count_q) begin
				in_packet_n = 1'b0;
				case (opcode_q)
					OP_INDEX_TYPE: begin
						if (count_q >= COUNT_W'(1)) begin
							if (p0[1:0] == 2'b00) begin
								ctx_n = ctx_q | 4'h8;
							end else begin
								ctx_n = ctx_q & 4'h7;
							end
						end
					end
					OP_DRAW_INDEX_AUTO: begin
						draw           = 1'b1;
						d.draw_indices = p0;
						d.topology     = p1[5:0];
					end
					OP_DRAW_INDEX_2: begin
						draw = 1'b1;
						if (count_q >= COUNT_W'(4)) begin
							d.draw_indices       = p0;
							d.index_base_address = {p2, p1};
							d.topology           = p3[5:0];
						end
					end
					OP_SET_CONTEXT_REG: begin
						if (count_q >= COUNT_W'(2)) begin
							case (p0[15:0])
								REG_RT_FORMAT: rt_n = p1;
								REG_DS_FORMAT: ds_n = p1;
								REG_BLEND:     ctx_n = {ctx_q[3:1], p1[0]};
								REG_DEPTH:     ctx_n = {ctx_q[3], p1[1], p1[0], ctx_q[0]};
								REG_VIEWPORT:  vp_n = p1;
								default: ;
							endcase
						end
					end
					default: ;
				endcase
			end else begin
				ppos_n = ppos_q + COUNT_W'(1);
			end
		end

		offset_n = (offset_q == OFFSET_MAX) ? offset_q : offset_q + OFFSET_BITS'(1);

		parsed = in_packet_n ? start_n : offset_n;
		if (OFFSET_BITS > PARSED_W && |(parsed >> PARSED_W)) begin
			parsed_sat = '1;
		end else begin
			parsed_sat = PARSED_W'(parsed);
		end

		s                      = '0;
		s.kind                 = KIND_SUMMARY;
		s.parsed_len           = parsed_sat;
		s.state_flags          = ctx_n;
		s.color_format         = rt_n;
		s.depth_surface_format = ds_n;
		s.vp_width             = vp_n[31:16];
		s.vp_height            = vp_n[15:0];
		s.packets_total        = tally_n;
		s.last                 = 1'b1;

		r0   = '0;
		r1   = s;
		nres = 2'd0;
		if (draw && last_s1) begin
			r0   = d;
			nres = 2'd2;
		end else if (draw) begin
			r0      = d;
			r0.last = 1'b1;
			nres    = 2'd1;
		end else if (last_s1) begin
			r0   = s;
			nres = 2'd1;
		end

		if (last_s1) begin
			in_packet_n = 1'b0;
			opcode_n    = '0;
			count_n     = '0;
			ppos_n      = '0;
			offset_n    = '0;
			start_n     = '0;
			ctx_n       = '0;
			rt_n        = '0;
			ds_n        = '0;
			vp_n        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			opcode_q    <= '0;
			count_q     <= '0;
			ppos_q      <= '0;
			offset_q    <= '0;
			start_q     <= '0;
			ctx_q       <= '0;
			rt_q        <= '0;
			ds_q        <= '0;
			vp_q        <= '0;
			tally_q     <= '0;
		end else if (adv) begin
			in_packet_q <= in_packet_n;
			opcode_q    <= opcode_n;
			count_q     <= count_n;
			ppos_q      <= ppos_n;
			offset_q    <= offset_n;
			start_q     <= start_n;
			ctx_q       <= ctx_n;
			rt_q        <= rt_n;
			ds_q        <= ds_n;
			vp_q        <= vp_n;
			tally_q     <= tally_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pl_write) begin
			payload_q[ppos_q[KEPT_IDX_W-1:0]] <= word_s1;
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			if (adv) begin
				wr_q <= wr_q + FIFO_PTR_W'(nres);
			end
			cnt_q <= cnt_q + (adv ? FIFO_CNT_W'(nres) : '0) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && nres != 2'd0) begin
			fifo_q[wr_q] <= r0;
		end
		if (adv && nres == 2'd2) begin
			fifo_q[wr_q + FIFO_PTR_W'(1)] <= r1;
		end
	end

	assign kind                 = fifo_q[rd_q].kind;
	assign draw_indices         = fifo_q[rd_q].draw_indices;
	assign index_base_address   = fifo_q[rd_q].index_base_address;
	assign topology             = fifo_q[rd_q].topology;
	assign parsed_len           = fifo_q[rd_q].parsed_len;
	assign state_flags          = fifo_q[rd_q].state_flags;
	assign color_format         = fifo_q[rd_q].color_format;
	assign depth_surface_format = fifo_q[rd_q].depth_surface_format;
	assign vp_width             = fifo_q[rd_q].vp_width;
	assign vp_height            = fifo_q[rd_q].vp_height;
	assign packets_total        = fifo_q[rd_q].packets_total;
	assign last                 = fifo_q[rd_q].last;

endmodule
`default_nettype wire

// ===== verif/tb_pm4_command_stream_parser.sv =====
// Testbench for the PM4 command stream parser: command stimulus, draw/summary predictor, scoreboard.
`timescale 1ns / 100ps
module tb_pm4_command_stream_parser;
	import pm4_csp_pkg::*;

	localparam logic [31:0] PARSED_MAX = (32'd1 << PARSED_W) - 1;
	localparam int unsigned RANDOM_WORDS = 550;

	typedef struct packed {
		logic [31:0] w;
		logic        lw;
		logic [1:0]  ph;
	} cmd_item_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [31:0] word = '0;
	logic last_word = 1'b0;
	logic rec_valid;
	logic rec_stall = 1'b0;
	logic kind;
	logic [31:0] draw_indices;
	logic [63:0] index_base_address;
	logic [5:0] topology;
	logic [PARSED_W-1:0] parsed_len;
	logic [3:0] state_flags;
	logic [31:0] color_format;
	logic [31:0] depth_surface_format;
	logic [15:0] vp_width;
	logic [15:0] vp_height;
	logic [31:0] packets_total;
	logic last;

	pm4_command_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.word(word),
		.last_word(last_word),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.kind(kind),
		.draw_indices(draw_indices),
		.index_base_address(index_base_address),
		.topology(topology),
		.parsed_len(parsed_len),
		.state_flags(state_flags),
		.color_format(color_format),
		.depth_surface_format(depth_surface_format),
		.vp_width(vp_width),
		.vp_height(vp_height),
		.packets_total(packets_total),
		.last(last)
	);

	cmd_item_t cmd_words[$];
	result_t pending_records[$];
	int unsigned words_total = 0;
	int unsigned words_accepted = 0;
	int unsigned counted_words = 0;
	int unsigned errors = 0;
	logic [1:0] recv_phase = '0;

	// parser state mirror
	logic in_pkt = 1'b0;
	logic [7:0] pkt_op = '0;
	logic [COUNT_W-1:0] pkt_cnt = '0;
	logic [COUNT_W-1:0] pay_pos = '0;
	logic [31:0] pay_kept [KEPT_PAYLOAD_WORDS] = '{default: '0};
	logic [OFFSET_BITS-1:0] word_ofs = '0;
	logic [OFFSET_BITS-1:0] pkt_ofs = '0;
	logic [3:0] ctx_flags = '0;
	logic [31:0] rt_fmt = '0;
	logic [31:0] ds_fmt = '0;
	logic [31:0] vp_size = '0;
	logic [31:0] hdr_tally = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [31:0] kept_word(int unsigned i);
		if (i > pkt_cnt || i >= KEPT_PAYLOAD_WORDS)
			return '0;
		return pay_kept[i[KEPT_IDX_W-1:0]];
	endfunction

	task automatic advance_parser(input logic [31:0] w, input logic lw);
		result_t rec;
		logic [OFFSET_BITS-1:0] pos;
		logic [31:0] p0;
		logic [31:0] p1;
		logic [31:0] parsed;
		logic [COUNT_W-1:0] p;
		pos = word_ofs;
		if (!in_pkt) begin
			if (w[31:30] == HDR_TYPE3) begin
				hdr_tally = hdr_tally + 32'd1;
				in_pkt = 1'b1;
				pkt_op = w[15:8];
				pkt_cnt = w[29:16];
				pay_pos = '0;
				pkt_ofs = pos;
			end
		end else begin
			p = pay_pos;
			if (p < KEPT_PAYLOAD_WORDS)
				pay_kept[p[KEPT_IDX_W-1:0]] = w;
			if (p >= pkt_cnt) begin
				in_pkt = 1'b0;
				p0 = kept_word(0);
				p1 = kept_word(1);
				rec = '0;
				rec.kind = KIND_DRAW;
				rec.last = !lw;
				case (pkt_op)
				OP_INDEX_TYPE: begin
					if (pkt_cnt >= 1)
						ctx_flags[3] = (p0[1:0] == 2'b00);
				end
				OP_DRAW_INDEX_AUTO: begin
					rec.draw_indices = p0;
					rec.topology = p1[5:0];
					pending_records = {pending_records, rec};
				end
				OP_DRAW_INDEX_2: begin
					if (pkt_cnt >= 4) begin
						rec.draw_indices = p0;
						rec.index_base_address = {kept_word(2), p1};
						rec.topology = 6'(kept_word(3));
					end
					pending_records = {pending_records, rec};
				end
				OP_SET_CONTEXT_REG: begin
					if (pkt_cnt >= 2) begin
						case (p0[15:0])
						REG_RT_FORMAT: rt_fmt = p1;
						REG_DS_FORMAT: ds_fmt = p1;
						REG_BLEND: ctx_flags[0] = p1[0];
						REG_DEPTH: begin
							ctx_flags[1] = p1[0];
							ctx_flags[2] = p1[1];
						end
						REG_VIEWPORT: vp_size = p1;
						default: ;
						endcase
					end
				end
				default: ;
				endcase
			end else begin
				pay_pos = p + 1'b1;
			end
		end
		word_ofs = (pos == '1) ? pos : pos + 1'b1;
		if (lw) begin
			parsed = in_pkt ? 32'(pkt_ofs) : 32'(word_ofs);
			if (parsed > PARSED_MAX)
				parsed = PARSED_MAX;
			rec = '0;
			rec.kind = KIND_SUMMARY;
			rec.parsed_len = parsed[PARSED_W-1:0];
			rec.state_flags = ctx_flags;
			rec.color_format = rt_fmt;
			rec.depth_surface_format = ds_fmt;
			rec.vp_width = vp_size[31:16];
			rec.vp_height = vp_size[15:0];
			rec.packets_total = hdr_tally;
			rec.last = 1'b1;
			pending_records = {pending_records, rec};
			in_pkt = 1'b0;
			pkt_op = '0;
			pkt_cnt = '0;
			pay_pos = '0;
			word_ofs = '0;
			pkt_ofs = '0;
			ctx_flags = '0;
			rt_fmt = '0;
			ds_fmt = '0;
			vp_size = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s expected %h got %h", $realtime, name, want, got);
		end
	endtask

	// sender: new transaction whenever the slot is free, random gaps per phase
	always @(posedge clk) begin : drive
		cmd_item_t nxt;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || !cmd_stall) begin
			if (cmd_valid) begin
				advance_parser(word, last_word);
				words_accepted++;
			end
			if (cmd_words.size() != 0 && $urandom_range(0, 99) >= ((cmd_words[0].ph == 0) ? 35 :
					(cmd_words[0].ph == 1) ? 86 : 0)) begin
				nxt = cmd_words.pop_front();
				word <= nxt.w;
				last_word <= nxt.lw;
				cmd_valid <= 1'b1;
				recv_phase <= nxt.ph;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		result_t want;
		if (!arst_n)
			rec_stall <= 1'b0;
		else
			rec_stall <= ($urandom_range(0, 99) < ((recv_phase == 0) ? 86 :
					(recv_phase == 1) ? 35 : 0));
		if (arst_n && rec_valid && !rec_stall) begin
			if (pending_records.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected record kind %b", $realtime, kind);
			end else begin
				want = pending_records.pop_front();
				check_field("kind", 64'(kind), 64'(want.kind));
				check_field("draw_indices", 64'(draw_indices), 64'(want.draw_indices));
				check_field("index_base_address", index_base_address, want.index_base_address);
				check_field("topology", 64'(topology), 64'(want.topology));
				check_field("parsed_len", 64'(parsed_len), 64'(want.parsed_len));
				check_field("state_flags", 64'(state_flags), 64'(want.state_flags));
				check_field("color_format", 64'(color_format), 64'(want.color_format));
				check_field("depth_surface_format", 64'(depth_surface_format),
					64'(want.depth_surface_format));
				check_field("vp_width", 64'(vp_width), 64'(want.vp_width));
				check_field("vp_height", 64'(vp_height), 64'(want.vp_height));
				check_field("packets_total", 64'(packets_total), 64'(want.packets_total));
				check_field("last", 64'(last), 64'(want.last));
			end
		end
	end

	task automatic queue_word(input logic [31:0] w, input logic lw, input logic [1:0] ph,
			input logic counted);
		cmd_item_t it;
		it.w = w;
		it.lw = lw;
		it.ph = ph;
		cmd_words = {cmd_words, it};
		if (counted)
			counted_words++;
	endtask

	function automatic logic [31:0] pkt_header(logic [7:0] op, logic [COUNT_W-1:0] cnt);
		logic [7:0] low;
		low = 8'($urandom_range(0, 255));
		return {HDR_TYPE3, cnt, op, low};
	endfunction

	initial begin : stim
		logic [31:0] w;
		logic [COUNT_W-1:0] cnt;
		logic [7:0] op;
		logic [15:0] reg_sel;
		logic [1:0] ph;
		logic end_pkt;
		logic lw;
		int unsigned pick;
		int unsigned j;

		// noise, index type, viewport, short context write
		queue_word(32'h3FFF_FFFF, 1'b0, 2'd0, 1'b0);
		queue_word(32'hBFFF_FFFF, 1'b0, 2'd0, 1'b0);
		queue_word(pkt_header(OP_INDEX_TYPE, 14'd1), 1'b0, 2'd0, 1'b1);
		queue_word(32'h0000_0000, 1'b0, 2'd0, 1'b1);
		queue_word(32'hFFFF_FFFF, 1'b0, 2'd0, 1'b1);
		queue_word(pkt_header(OP_SET_CONTEXT_REG, 14'd2), 1'b0, 2'd0, 1'b1);
		queue_word({16'hFFFF, REG_VIEWPORT}, 1'b0, 2'd0, 1'b1);
		queue_word(32'hFFFF_FFFF, 1'b0, 2'd0, 1'b1);
		queue_word(32'h0000_0000, 1'b0, 2'd0, 1'b1);
		queue_word(pkt_header(OP_SET_CONTEXT_REG, 14'd1), 1'b0, 2'd0, 1'b1);
		queue_word({16'h0000, REG_BLEND}, 1'b0, 2'd0, 1'b1);
		queue_word(32'h0000_0001, 1'b0, 2'd0, 1'b1);
		// auto draw with no payload beyond the count
		queue_word(pkt_header(OP_DRAW_INDEX_AUTO, 14'd0), 1'b0, 2'd0, 1'b1);
		queue_word(32'hFFFF_FFFF, 1'b0, 2'd0, 1'b1);
		// indexed draw too short, then full indexed draw ending the buffer
		queue_word(pkt_header(OP_DRAW_INDEX_2, 14'd3), 1'b0, 2'd0, 1'b1);
		for (j = 0; j < 4; j++)
			queue_word(32'hFFFF_FFFF, 1'b0, 2'd0, 1'b1);
		queue_word(pkt_header(OP_DRAW_INDEX_2, 14'd4), 1'b0, 2'd0, 1'b1);
		for (j = 0; j < 4; j++)
			queue_word(32'hFFFF_FFFF, 1'b0, 2'd0, 1'b1);
		queue_word(32'h0000_0000, 1'b1, 2'd0, 1'b1);
		// truncated trailing packet, then header on the buffer's last word
		queue_word(pkt_header(OP_DRAW_INDEX_AUTO, 14'd2), 1'b0, 2'd0, 1'b1);
		queue_word(32'h0000_0001, 1'b0, 2'd0, 1'b1);
		queue_word(32'h0000_0002, 1'b1, 2'd0, 1'b1);
		queue_word(pkt_header(OP_DRAW_INDEX_AUTO, 14'h3FFF), 1'b1, 2'd0, 1'b1);

		counted_words = 0;
		while (counted_words < RANDOM_WORDS) begin
			ph = 2'(counted_words * 3 / RANDOM_WORDS);
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				w = $urandom;
				w[31:30] = 2'($urandom_range(0, 2));
				queue_word(w, $urandom_range(0, 19) == 0, ph, 1'b0);
			end else if (pick < 17) begin
				w = $urandom;
				w[31:30] = HDR_TYPE3;
				queue_word(w, 1'b1, ph, 1'b1);
			end else begin
				case ($urandom_range(0, 5))
				0: begin
					op = OP_DRAW_INDEX_AUTO;
					cnt = 14'd1;
				end
				1: begin
					op = OP_DRAW_INDEX_2;
					cnt = 14'd4;
				end
				2: begin
					op = OP_INDEX_TYPE;
					cnt = 14'd1;
				end
				3, 4: begin
					op = OP_SET_CONTEXT_REG;
					cnt = 14'd2;
				end
				default: begin
					op = 8'($urandom_range(0, 255));
					cnt = COUNT_W'($urandom_range(0, 5));
				end
				endcase
				if ($urandom_range(0, 3) == 0)
					cnt = COUNT_W'($urandom_range(0, 7));
				end_pkt = ($urandom_range(0, 9) == 0);
				lw = ($urandom_range(0, 39) == 0);
				queue_word(pkt_header(op, cnt), lw, ph, 1'b1);
				for (j = 0; j <= cnt && !lw; j++) begin
					w = $urandom;
					if (op == OP_SET_CONTEXT_REG && j == 0) begin
						case ($urandom_range(0, 5))
						0: reg_sel = REG_RT_FORMAT;
						1: reg_sel = REG_DS_FORMAT;
						2: reg_sel = REG_BLEND;
						3: reg_sel = REG_DEPTH;
						4: reg_sel = REG_VIEWPORT;
						default: reg_sel = 16'($urandom_range(0, 65535));
						endcase
						w[15:0] = reg_sel;
					end
					lw = (j == cnt && end_pkt) || ($urandom_range(0, 39) == 0);
					queue_word(w, lw, ph, 1'b1);
				end
			end
		end
		words_total = cmd_words.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (words_accepted != words_total)
			@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0 && pending_records.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== pm4_command_stream_parser.f =====
hdl/pm4_csp_pkg.sv
hdl/pm4_command_stream_parser.sv
verif/tb_pm4_command_stream_parser.sv
